[design/imhq_pkg.sv]
`default_nettype none
package imhq_pkg;

  localparam int DefCapacity = 64;
  localparam int DefKeyBits  = 10;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_PEEK   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_DUP    = 3'd2,
    ST_FULL   = 3'd3,
    ST_ABSENT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_TAKE,
    S_FILL,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_PLACE,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic clr_step;     // write one invalid entry of the position table
    logic latch_in;     // capture key, clear result key
    logic rd_root;      // read heap slot 0
    logic do_push;      // hole at old count, count up
    logic do_take;      // invalidate removed key, hole at its slot
    logic take_root;    // removal target is the root
    logic set_out;      // report root key
    logic shrink;       // count down
    logic rd_last;      // read last entry
    logic fill;         // last entry becomes the moving key
    logic rd_parent;    // read parent of the hole
    logic move_up;      // parent drops into the hole
    logic rd_left;      // read left child
    logic rd_right;     // read right child
    logic move_dn;      // best child rises into the hole
    logic place;        // moving key written at the hole
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic present;
    logic empty;
    logic full;
    logic hole_is_last;
    logic at_root;
    logic up_wins;      // moving key precedes parent
    logic has_left;
    logic dn_swap;      // a child precedes the moving key
  } stat_t;

endpackage
`default_nettype wire

[design/imhq_ctrl.sv]
`default_nettype none
module imhq_ctrl
  import imhq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  input  wire logic [1:0] operation,
  output logic       busy,
  output logic       done,
  output logic [2:0] status,
  output cmd_t       cmd,
  input  stat_t      st
);

  state_t  state, state_next;
  op_t     op, op_next;
  status_t res_st, res_st_next;
  logic    sink_ok, sink_ok_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      op <= OP_PUSH;
      res_st <= ST_OK;
      sink_ok <= 1'b0;
    end else begin
      state <= state_next;
      op <= op_next;
      res_st <= res_st_next;
      sink_ok <= sink_ok_next;
    end
  end

  assign status = res_st;

  always_comb begin
    state_next = state;
    op_next = op;
    res_st_next = res_st;
    sink_ok_next = sink_ok;
    cmd = '0;
    busy = (state != S_IDLE);
    done = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          op_next = op_t'(operation);
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.rd_root = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        res_st_next = ST_OK;
        sink_ok_next = 1'b0;
        state_next = S_DONE;
        unique case (op)
          OP_PUSH: begin
            if (st.present) res_st_next = ST_DUP;
            else if (st.full) res_st_next = ST_FULL;
            else begin
              cmd.do_push = 1'b1;
              state_next = S_UP_RD;
            end
          end
          OP_POP: begin
            if (st.empty) res_st_next = ST_EMPTY;
            else begin
              cmd.set_out = 1'b1;
              cmd.do_take = 1'b1;
              cmd.take_root = 1'b1;
              state_next = S_TAKE;
            end
          end
          OP_REMOVE: begin
            if (!st.present) res_st_next = ST_ABSENT;
            else begin
              cmd.do_take = 1'b1;
              state_next = S_TAKE;
            end
          end
          OP_PEEK: begin
            if (st.empty) res_st_next = ST_EMPTY;
            else cmd.set_out = 1'b1;
          end
        endcase
      end
      S_TAKE: begin
        cmd.shrink = 1'b1;
        if (st.hole_is_last) state_next = S_DONE;
        else begin
          cmd.rd_last = 1'b1;
          sink_ok_next = 1'b1;
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        state_next = S_UP_RD;
      end
      S_UP_RD: begin
        if (st.at_root) state_next = sink_ok ? S_DN_RDL : S_PLACE;
        else begin
          cmd.rd_parent = 1'b1;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.up_wins) begin
          cmd.move_up = 1'b1;
          sink_ok_next = 1'b0;
          state_next = S_UP_RD;
        end else state_next = sink_ok ? S_DN_RDL : S_PLACE;
      end
      S_DN_RDL: begin
        if (st.has_left) begin
          cmd.rd_left = 1'b1;
          state_next = S_DN_RDR;
        end else state_next = S_PLACE;
      end
      S_DN_RDR: begin
        cmd.rd_right = 1'b1;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (st.dn_swap) begin
          cmd.move_dn = 1'b1;
          state_next = S_DN_RDL;
        end else state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[design/imhq_dp.sv]
`default_nettype none
module imhq_dp
  import imhq_pkg::*;
#(
  parameter int CAPACITY = DefCapacity,
  parameter int KEY_BITS = DefKeyBits
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                max_first,
  input  wire logic [KEY_BITS-1:0] key,
  input  cmd_t                     cmd,
  output stat_t                    st,
  output logic [KEY_BITS-1:0]      out_key,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam int LW = SW + 2;
  localparam int KS = 1 << KEY_BITS;

  logic [KEY_BITS-1:0] heap_mem [CAPACITY];
  logic [SW:0]         pos_mem  [KS];   // valid bit and slot

  logic [KEY_BITS-1:0] k_in;
  logic [CW-1:0]       count;
  logic [LW-1:0]       count_l;
  logic [KEY_BITS-1:0] clr_idx;
  logic [SW-1:0]       cur, oth;        // hole slot, parent slot
  logic [KEY_BITS-1:0] cur_key, left_key;
  logic                right_ok;
  logic [SW:0]         pos_rd;

  // heap memory ports
  logic                h_re;
  logic [SW-1:0]       h_ra;
  logic [KEY_BITS-1:0] h_rd;
  logic                h_we;
  logic [SW-1:0]       h_wa;
  logic [KEY_BITS-1:0] h_wd;
  // position table write port
  logic                p_we;
  logic [KEY_BITS-1:0] p_wa;
  logic [SW:0]         p_wd;

  logic [SW-1:0]       parent, last_slot, best_slot;
  logic [LW-1:0]       l_child, r_child;
  logic [KEY_BITS-1:0] gone_key, best_key;
  logic                left_wins, best_is_r;

  function automatic logic prec(input logic mf, input logic [KEY_BITS-1:0] a,
                                input logic [KEY_BITS-1:0] b);
    prec = mf ? (a > b) : (a < b);
  endfunction

  assign count_l   = LW'(count);
  assign parent    = (cur - SW'(1)) >> 1;
  assign last_slot = SW'(count - CW'(1));
  assign l_child   = (LW'(cur) << 1) + LW'(1);
  assign r_child   = l_child + LW'(1);
  assign gone_key  = cmd.take_root ? h_rd : k_in;

  // sink choice: best of moving key, left child and right child
  assign left_wins = prec(max_first, left_key, cur_key);
  assign best_is_r = right_ok && prec(max_first, h_rd, left_wins ? left_key : cur_key);
  assign best_key  = best_is_r ? h_rd : left_key;
  assign best_slot = best_is_r ? r_child[SW-1:0] : l_child[SW-1:0];

  // clocked memories
  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    if (h_re) h_rd <= heap_mem[h_ra];
  end
  always_ff @(posedge clk) begin
    if (p_we) pos_mem[p_wa] <= p_wd;
    pos_rd <= pos_mem[k_in];
  end

  // read address selection
  always_comb begin
    h_re = cmd.rd_root || cmd.rd_last || cmd.rd_parent || cmd.rd_left || cmd.rd_right;
    h_ra = cur;
    if (cmd.rd_root) h_ra = '0;
    else if (cmd.rd_last) h_ra = last_slot;
    else if (cmd.rd_parent) h_ra = parent;
    else if (cmd.rd_left) h_ra = l_child[SW-1:0];
    else if (cmd.rd_right) h_ra = r_child[SW-1:0];
  end

  // the moving key is only written once it has found its slot
  always_comb begin
    h_we = 1'b0; h_wa = cur; h_wd = cur_key;
    if (cmd.move_up) begin
      h_we = 1'b1; h_wd = h_rd;
    end else if (cmd.move_dn) begin
      h_we = 1'b1; h_wd = best_key;
    end else if (cmd.place) begin
      h_we = 1'b1;
    end
  end

  always_comb begin
    p_we = 1'b0; p_wa = cur_key; p_wd = {1'b1, cur};
    if (cmd.clr_step) begin
      p_we = 1'b1; p_wa = clr_idx; p_wd = '0;
    end else if (cmd.do_take) begin
      p_we = 1'b1; p_wa = gone_key; p_wd = '0;
    end else if (cmd.move_up) begin
      p_we = 1'b1; p_wa = h_rd;
    end else if (cmd.move_dn) begin
      p_we = 1'b1; p_wa = best_key;
    end else if (cmd.place) begin
      p_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      clr_idx <= '0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + KEY_BITS'(1);
      if (cmd.do_push) count <= count + CW'(1);
      else if (cmd.shrink) count <= count - CW'(1);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      k_in <= key;
      out_key <= '0;
    end
    if (cmd.set_out) out_key <= h_rd;
    if (cmd.do_push) begin
      cur <= SW'(count);
      cur_key <= k_in;
    end
    if (cmd.do_take) cur <= cmd.take_root ? '0 : pos_rd[SW-1:0];
    if (cmd.fill) cur_key <= h_rd;
    if (cmd.rd_parent) oth <= parent;
    if (cmd.move_up) cur <= oth;
    if (cmd.rd_right) begin
      left_key <= h_rd;
      right_ok <= (r_child < count_l);
    end
    if (cmd.move_dn) cur <= best_slot;
  end

  always_comb begin
    st = '0;
    st.clr_last = (clr_idx == '1);
    st.present = pos_rd[SW] && (CW'(pos_rd[SW-1:0]) < count);
    st.empty = (count == '0);
    st.full = (count >= CW'(CAPACITY));
    st.hole_is_last = (CW'(cur) == count - CW'(1));
    st.at_root = (cur == '0);
    st.up_wins = prec(max_first, cur_key, h_rd);
    st.has_left = (l_child < count_l);
    st.dn_swap = left_wins || best_is_r;
  end

  assign entry_count = count;

endmodule
`default_nettype wire

[design/indexed_min_heap_queue_top.sv]
`default_nettype none
// indexed binary heap priority queue, one result beat per command; results cannot stall
// peek and refused commands go straight to the result beat; a push sifts up, and a pop
// or remove sifts up or down, with one memory read per sift-up step and two per
// sift-down step; busy is high throughout
// the next command is taken in the idle state that follows the result beat
// reset: synchronous; the position table is then swept clear, one entry a cycle across
// all 2^KEY_BITS entries, with busy high
module indexed_min_heap_queue_top
  import imhq_pkg::*;
#(
  parameter int CAPACITY = DefCapacity,
  parameter int KEY_BITS = DefKeyBits
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          operation,
  input  wire logic [KEY_BITS-1:0] key,
  input  wire logic                cfg_we,
  input  wire logic                cfg_wdata,
  output logic                     done,
  output logic [2:0]               status,
  output logic [KEY_BITS-1:0]      out_key,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t  cmd;
  stat_t st;
  logic  max_first;

  // order register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) max_first <= 1'b0;
    else if (cfg_we) max_first <= cfg_wdata;
  end

  imhq_ctrl u_ctrl (
    .clk, .rst, .start, .operation, .busy, .done, .status, .cmd, .st
  );

  imhq_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_eng (
    .clk, .rst, .max_first, .key, .cmd, .st, .out_key, .entry_count
  );

  // busy while a result beat is out
  assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat without busy");
  // a result beat lasts one cycle
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result beat held");
  // an accepted command makes the block busy
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("command beat not taken");
  // count never exceeds capacity
  assert property (@(posedge clk) disable iff (rst) entry_count <= CW'(CAPACITY))
    else $error("count above capacity");

endmodule
`default_nettype wire

[verif/indexed_min_heap_queue_top_tb.sv]
`default_nettype none
module indexed_min_heap_queue_top_tb
  import imhq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Cap      = DefCapacity;
  localparam int KeyBits  = DefKeyBits;
  localparam int KeySpace = 1 << KeyBits;
  localparam int CntBits  = $clog2(Cap + 1);
  // the watchdog limit covers the clear sweep after reset and the longest heap op
  localparam int StallLimit = 4 * KeySpace + 2000;
  localparam int DrainCycles = 40;

  typedef struct {
    status_t             st;
    logic [KeyBits-1:0]  k;
    logic [CntBits-1:0]  cnt;
  } heap_result_t;

  // shadow heap and the queue of results it predicts
  class heap_scoreboard;
    logic [KeyBits-1:0] slot_key [Cap];
    int                 key_slot [KeySpace];
    bit                 held [KeySpace];
    int                 held_count;
    bit                 largest_on_top;
    heap_result_t       awaited [$];
    int                 errors;
    int                 checked;
    int                 seen_status [5];

    function new();
      for (int i = 0; i < KeySpace; i++) begin
        held[i] = 0;
        key_slot[i] = 0;
      end
      held_count = 0;
      largest_on_top = 0;
      errors = 0;
      checked = 0;
    endfunction

    function bit above(logic [KeyBits-1:0] a, logic [KeyBits-1:0] b);
      return largest_on_top ? (a > b) : (a < b);
    endfunction

    function void place(int slot, logic [KeyBits-1:0] k);
      slot_key[slot] = k;
      key_slot[k] = slot;
    endfunction

    function void swap_slots(int i, int j);
      logic [KeyBits-1:0] ki, kj;
      ki = slot_key[i];
      kj = slot_key[j];
      place(i, kj);
      place(j, ki);
    endfunction

    function void bubble_up(int slot);
      int parent;
      while (slot > 0) begin
        parent = (slot - 1) / 2;
        if (!above(slot_key[slot], slot_key[parent])) break;
        swap_slots(slot, parent);
        slot = parent;
      end
    endfunction

    function void bubble_down(int slot);
      int l, r, best;
      forever begin
        l = 2 * slot + 1;
        r = l + 1;
        best = slot;
        if (l < held_count && above(slot_key[l], slot_key[best])) best = l;
        if (r < held_count && above(slot_key[r], slot_key[best])) best = r;
        if (best == slot) break;
        swap_slots(slot, best);
        slot = best;
      end
    endfunction

    // pull the entry at slot out, back-filling with the last entry
    function void extract(int slot);
      int last;
      last = held_count - 1;
      held[slot_key[slot]] = 0;
      if (slot == last) begin
        held_count = last;
        return;
      end
      place(slot, slot_key[last]);
      held_count = last;
      if (slot > 0 && above(slot_key[slot], slot_key[(slot - 1) / 2])) bubble_up(slot);
      else bubble_down(slot);
    endfunction

    // an accepted command beat
    function void note_command(op_t op, logic [KeyBits-1:0] k);
      heap_result_t r;
      r.st = ST_OK;
      r.k = '0;
      case (op)
        OP_PUSH: begin
          if (held[k]) r.st = ST_DUP;
          else if (held_count >= Cap) r.st = ST_FULL;
          else begin
            place(held_count, k);
            held[k] = 1;
            held_count++;
            bubble_up(held_count - 1);
          end
        end
        OP_POP: begin
          if (held_count == 0) r.st = ST_EMPTY;
          else begin
            r.k = slot_key[0];
            extract(0);
          end
        end
        OP_REMOVE: begin
          if (!held[k]) r.st = ST_ABSENT;
          else extract(key_slot[k]);
        end
        default: begin
          if (held_count == 0) r.st = ST_EMPTY;
          else r.k = slot_key[0];
        end
      endcase
      r.cnt = held_count[CntBits-1:0];
      awaited.push_back(r);
    endfunction

    // a result beat on the done strobe
    function void check_result(logic [2:0] st, logic [KeyBits-1:0] k,
                               logic [CntBits-1:0] cnt);
      heap_result_t e;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited: status %0d key %0d count %0d",
                 $time, st, k, cnt);
        errors++;
        return;
      end
      e = awaited.pop_front();
      checked++;
      if (e.st <= ST_ABSENT) seen_status[e.st]++;
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
      if (k !== e.k) begin
        $display("%0t: out_key expected %0d actual %0d", $time, e.k, k);
        errors++;
      end
      if (cnt !== e.cnt) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, e.cnt, cnt);
        errors++;
      end
    endfunction

    // some key that is currently in the heap, or a random one if empty
    function logic [KeyBits-1:0] some_held_key();
      if (held_count == 0) return KeyBits'($urandom_range(KeySpace - 1, 0));
      return slot_key[$urandom_range(held_count - 1, 0)];
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               start = 0;
  logic [1:0]         operation = '0;
  logic [KeyBits-1:0] key = '0;
  logic               cfg_we = 0;
  logic               cfg_wdata = 0;
  logic               busy;
  logic               done;
  logic [2:0]         status;
  logic [KeyBits-1:0] out_key;
  logic [CntBits-1:0] entry_count;

  heap_scoreboard sb = new();
  int stall_cycles = 0;
  int cmd_beats = 0;

  indexed_min_heap_queue_top dut (
    .clk, .rst, .start, .busy, .operation, .key,
    .cfg_we, .cfg_wdata, .done, .status, .out_key, .entry_count
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // result side: the receiver never stalls, every strobed beat is checked
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, out_key, entry_count);
  end

  // watchdog on cycles without any beat on either side
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles", stall_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // one command beat; start stays high afterwards so back-to-back beats
  // never drop and re-raise it in the same step
  task automatic send_cmd(op_t op, logic [KeyBits-1:0] k, int gap);
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    operation <= op;
    key <= k;
    do @(posedge clk); while (busy);
    sb.note_command(op, k);
    cmd_beats++;
  endtask

  task automatic wait_results();
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // register write only once the block has gone quiet
  task automatic set_order(bit largest);
    start <= 0;
    wait_results();
    repeat (8) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= largest;
    @(posedge clk);
    cfg_we <= 0;
    sb.largest_on_top = largest;
  endtask

  // weighted operation pick, percentages for push, pop and remove
  function automatic op_t pick_op(int push_pct, int pop_pct, int rem_pct);
    int d;
    d = $urandom_range(99, 0);
    if (d < push_pct) return OP_PUSH;
    if (d < push_pct + pop_pct) return OP_POP;
    if (d < push_pct + pop_pct + rem_pct) return OP_REMOVE;
    return OP_PEEK;
  endfunction

  // mix of full-range keys, held keys (duplicates, real removes) and a tight
  // pool that collides often
  function automatic logic [KeyBits-1:0] pick_key();
    int d;
    d = $urandom_range(9, 0);
    if (d < 4) return KeyBits'($urandom_range(KeySpace - 1, 0));
    if (d < 7) return sb.some_held_key();
    return KeyBits'($urandom_range(15, 0));
  endfunction

  task automatic random_phase(int n, int push_pct, int pop_pct, int rem_pct);
    op_t op;
    for (int i = 0; i < n; i++) begin
      op = pick_op(push_pct, pop_pct, rem_pct);
      // every fifth stretch goes back to back with no gaps
      send_cmd(op, pick_key(), (i / 40) % 5 == 0 ? 0 : $urandom_range(4, 0));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: empty cases, key extremes, duplicates, every operation
    send_cmd(OP_PEEK, '0, 0);
    send_cmd(OP_POP, '0, 1);
    send_cmd(OP_REMOVE, '0, 0);
    send_cmd(OP_REMOVE, '1, 2);
    send_cmd(OP_PUSH, '1, 0);
    send_cmd(OP_PUSH, '0, 0);
    send_cmd(OP_PUSH, '0, 3);
    send_cmd(OP_PEEK, '0, 0);
    send_cmd(OP_PUSH, 10'h200, 0);
    send_cmd(OP_PUSH, 10'h155, 4);
    send_cmd(OP_PUSH, 10'h2aa, 0);
    send_cmd(OP_REMOVE, 10'h200, 0);
    send_cmd(OP_REMOVE, 10'h005, 1);
    send_cmd(OP_PEEK, '1, 0);
    send_cmd(OP_POP, '1, 0);
    send_cmd(OP_POP, '0, 0);
    send_cmd(OP_REMOVE, '1, 0);
    send_cmd(OP_POP, '0, 2);
    send_cmd(OP_POP, '0, 0);
    send_cmd(OP_PEEK, '0, 0);

    // largest first: fill past capacity, then drain and churn
    set_order(1);
    random_phase(220, 75, 5, 10);
    random_phase(200, 20, 40, 30);
    set_order(0);
    random_phase(220, 75, 5, 10);
    random_phase(220, 40, 25, 25);
    set_order(1);
    random_phase(200, 45, 20, 25);
    set_order(0);
    random_phase(200, 15, 50, 25);

    start <= 0;
    wait_results();
    repeat (DrainCycles) @(posedge clk);

    $display("%0d commands, %0d results checked, both orderings", cmd_beats, sb.checked);
    $display("status counts ok %0d empty %0d dup %0d full %0d absent %0d",
             sb.seen_status[ST_OK], sb.seen_status[ST_EMPTY], sb.seen_status[ST_DUP],
             sb.seen_status[ST_FULL], sb.seen_status[ST_ABSENT]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

[indexed_min_heap_queue_top.f]
design/imhq_pkg.sv
design/imhq_ctrl.sv
design/imhq_dp.sv
design/indexed_min_heap_queue_top.sv
verif/indexed_min_heap_queue_top_tb.sv
